FILE: hdl/bafr_pkg.sv
// shared constants and codes for the bump allocator with frames
`default_nettype none
package bafr_pkg;

    // sizing
    localparam int OFFSET_BITS = 16;
    localparam int MAX_MARKS   = 16;

    // fixed field widths
    localparam int FIELD_W = 17;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

    // derived internal widths
    localparam int NF_W   = OFFSET_BITS + 1;
    localparam int SUM_W  = ((NF_W > FIELD_W) ? NF_W : FIELD_W) + 1;
    localparam int MCNT_W = $clog2(MAX_MARKS + 1);
    localparam int MIDX_W = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMEM = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef logic [NF_W-1:0] t_offset;

endpackage
`default_nettype wire

FILE: hdl/bump_allocator_with_frames_top.sv
// top level of the arena bump allocator with a stack of saved marks
//
// Input channel s_*: one command per item; s_tuser carries the command code,
// s_tdata carries the byte count of an allocate request.
// Output channel m_*: one result per command; m_tuser carries the status,
// m_tdata carries the granted offset or the current offset.
// Config port: i_cfg_we with i_cfg_wdata writes the pool size, which also
// rewinds the offset to zero and drops all marks; write it only when idle.
// The result register is loaded at the edge that accepts the command.
// Throughput is one command per cycle while the receiver takes results, set
// by the add/compare and the mark register file read in that cycle.
// When the receiver stalls, the result is held and s_tready drops until the
// held result is taken (s_tready is high whenever the result register is
// empty or being drained in the same cycle).
// Reset (synchronous, active low) clears the pool size, the offset, the mark
// count and the output valid; no clearing pass is needed.
`default_nettype none
module bump_allocator_with_frames_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_wdata,   // pool_size
    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // [16:0] num_bytes, [23:17] zero
    input  wire logic [1:0]  s_tuser,       // [1:0] command
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,       // [16:0] offset, [23:17] zero
    output logic [1:0]       m_tuser        // [1:0] status
);

    // state registers
    logic [bafr_pkg::FIELD_W-1:0]  r_pool_size;
    bafr_pkg::t_offset             r_next_free, n_next_free;
    logic [bafr_pkg::MCNT_W-1:0]   r_mark_count, n_mark_count;
    bafr_pkg::t_offset             r_marks [bafr_pkg::MAX_MARKS];
    logic                          r_m_valid;
    logic [bafr_pkg::STAT_W-1:0]   r_status, n_status;
    logic [bafr_pkg::FIELD_W-1:0]  r_offset, n_offset;

    logic                          accept;
    logic                          push_en;
    logic [bafr_pkg::FIELD_W-1:0]  req;
    logic [bafr_pkg::CMD_W-1:0]    cmd;
    logic [bafr_pkg::SUM_W-1:0]    alloc_end;
    logic [bafr_pkg::SUM_W-1:0]    pool_ext;
    logic [bafr_pkg::SUM_W-1:0]    cap_limit;
    logic [bafr_pkg::SUM_W-1:0]    capacity;
    logic [bafr_pkg::MCNT_W-1:0]   cnt_m1;
    logic                          stk_empty;
    logic                          stk_full;
    bafr_pkg::t_offset             top_mark;

    // handshake
    assign s_tready = !r_m_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign req      = s_tdata[bafr_pkg::FIELD_W-1:0];
    assign cmd      = s_tuser;

    // capacity is the pool size clamped to the offset range
    assign cap_limit = bafr_pkg::SUM_W'(1) << bafr_pkg::OFFSET_BITS;
    assign pool_ext  = bafr_pkg::SUM_W'(r_pool_size);
    assign capacity  = (pool_ext < cap_limit) ? pool_ext : cap_limit;
    assign alloc_end = bafr_pkg::SUM_W'(r_next_free) + bafr_pkg::SUM_W'(req);

    // mark stack top
    assign cnt_m1    = r_mark_count - bafr_pkg::MCNT_W'(1);
    assign stk_empty = (r_mark_count == '0);
    assign stk_full  = (r_mark_count >= bafr_pkg::MCNT_W'(bafr_pkg::MAX_MARKS));
    assign top_mark  = r_marks[cnt_m1[bafr_pkg::MIDX_W-1:0]];

    // command decode and next state
    always_comb begin
        n_next_free  = r_next_free;
        n_mark_count = r_mark_count;
        n_status     = bafr_pkg::ST_OK;
        n_offset     = bafr_pkg::FIELD_W'(r_next_free);
        push_en      = 1'b0;
        case (cmd)
            bafr_pkg::CMD_ALLOC: begin
                if (alloc_end <= capacity) begin
                    n_next_free = alloc_end[bafr_pkg::NF_W-1:0];
                end else begin
                    n_status = bafr_pkg::ST_NOMEM;
                end
            end
            bafr_pkg::CMD_PUSH: begin
                if (stk_full) begin
                    n_status = bafr_pkg::ST_FULL;
                end else begin
                    push_en      = 1'b1;
                    n_mark_count = r_mark_count + bafr_pkg::MCNT_W'(1);
                end
            end
            bafr_pkg::CMD_POP: begin
                if (stk_empty) begin
                    n_status = bafr_pkg::ST_EMPTY;
                end else begin
                    n_mark_count = cnt_m1;
                    n_next_free  = top_mark;
                    n_offset     = bafr_pkg::FIELD_W'(top_mark);
                end
            end
            default: begin
                n_next_free = stk_empty ? '0 : top_mark;
                n_offset    = stk_empty ? '0 : bafr_pkg::FIELD_W'(top_mark);
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size  <= '0;
            r_next_free  <= '0;
            r_mark_count <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool_size  <= i_cfg_wdata;
                r_next_free  <= '0;
                r_mark_count <= '0;
            end else if (accept) begin
                r_next_free  <= n_next_free;
                r_mark_count <= n_mark_count;
            end
            if (accept) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // mark storage and result payload
    always_ff @(posedge i_clk) begin
        if (accept && push_en) begin
            r_marks[r_mark_count[bafr_pkg::MIDX_W-1:0]] <= r_next_free;
        end
        if (accept) begin
            r_status <= n_status;
            r_offset <= n_offset;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_status;
    assign m_tdata  = {{(bafr_pkg::TDATA_W - bafr_pkg::FIELD_W){1'b0}}, r_offset};

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark_count <= bafr_pkg::MCNT_W'(bafr_pkg::MAX_MARKS))
        else $error("mark count above stack depth");

    a_free_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bafr_pkg::SUM_W'(r_next_free) <= capacity)
        else $error("next free offset beyond capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_we && cmd == bafr_pkg::CMD_PUSH && !stk_full)
        |=> (r_mark_count == $past(r_mark_count) + bafr_pkg::MCNT_W'(1)))
        else $error("push did not add a mark");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_next_free == '0 && r_mark_count == '0))
        else $error("pool size write did not rewind");

endmodule
`default_nettype wire
